>>> rtl/core/equirect_env_map_lookup_assert.svh
// Assertion macros used by the environment map lookup top level.
`ifndef EQUIRECT_ENV_MAP_LOOKUP_ASSERT_SVH
`define EQUIRECT_ENV_MAP_LOOKUP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define EQMAP_ASSERT_NOW(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("eqmap assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define EQMAP_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("eqmap assertion failed");

`endif

>>> rtl/core/eqmap_pkg.sv
// Package: types, constants and the arctangent table of the environment map lookup.
`timescale 1ns / 1ps
package eqmap_pkg;

	localparam int MAP_WIDTH_DEF  = 512;
	localparam int MAP_HEIGHT_DEF = 256;

	localparam int STORE_AW      = 17;
	localparam int STORE_DEPTH   = 1 << STORE_AW;
	localparam int TEXEL_W       = 24;
	localparam int COL_W         = 12;
	localparam int ROW_W         = 11;
	localparam int DIM_W         = 13;

	localparam int SQRT_STAGES   = 30;
	localparam int ROOT_W        = 30;
	localparam int REM_W         = 34;
	localparam int SUMSQ_W       = 32;

	localparam int CORDIC_STEPS  = 28;
	localparam int CORDIC_LAT    = CORDIC_STEPS + 1;
	localparam int VEC_W         = 34;
	localparam int PHASE_W       = 32;

	localparam logic [PHASE_W-1:0] PHASE_QUARTER = 32'h4000_0000;
	localparam logic [PHASE_W-1:0] PHASE_HALF    = 32'h8000_0000;
	localparam logic [PHASE_W-1:0] PHASE_3QUART  = 32'hC000_0000;

	localparam logic [PHASE_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef enum logic {
		ACT_WRITE  = 1'b0,
		ACT_LOOKUP = 1'b1
	} action_t;

	typedef struct packed {
		action_t                    action;
		logic signed [15:0]         dir_x;
		logic signed [15:0]         dir_y;
		logic signed [15:0]         dir_z;
		logic [STORE_AW-1:0]        texel_index;
		logic [TEXEL_W-1:0]         texel;
	} item_t;

endpackage

>>> rtl/core/eqmap_sqrt.sv
// Pipelined integer square root of sumsq * 2^28, one result bit per stage.
`timescale 1ns / 1ps
module eqmap_sqrt import eqmap_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic [SUMSQ_W-1:0] sumsq,
	output logic [ROOT_W-1:0]  root
);

	logic [SUMSQ_W-1:0] src_q  [SQRT_STAGES];
	logic [REM_W-1:0]   rem_q  [SQRT_STAGES];
	logic [ROOT_W-1:0]  root_q [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [SUMSQ_W-1:0] src_i;
		logic [REM_W-1:0]   rem_i;
		logic [ROOT_W-1:0]  root_i;
		logic [REM_W-1:0]   rem_sh;
		logic [REM_W-1:0]   trial;

		if (k == 0) begin : g_first
			assign src_i  = sumsq;
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign src_i  = src_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
		end

		// bring down the next digit pair; the low 28 input bits are zero
		assign rem_sh = {rem_i[REM_W-3:0], src_i[SUMSQ_W-1 -: 2]};
		assign trial  = REM_W'({root_i, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				src_q[k] <= {src_i[SUMSQ_W-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q[k]  <= rem_sh - trial;
					root_q[k] <= {root_i[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q[k]  <= rem_sh;
					root_q[k] <= {root_i[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_q[SQRT_STAGES-1];

endmodule

>>> rtl/core/eqmap_cordic.sv
// Pipelined vectoring CORDIC: phase of atan2(a, b) in 2^-32 turns.
`timescale 1ns / 1ps
module eqmap_cordic import eqmap_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [VEC_W-1:0] a_in,
	input  logic signed [VEC_W-1:0] b_in,
	output logic [PHASE_W-1:0]      phase
);

	logic signed [VEC_W-1:0] na;
	logic signed [VEC_W-1:0] nb;
	logic [PHASE_W-1:0]      p0;
	logic                    done0;

	logic signed [VEC_W-1:0] a0_q;
	logic signed [VEC_W-1:0] b0_q;
	logic [PHASE_W-1:0]      p0_q;
	logic                    done0_q;

	logic signed [VEC_W-1:0] a_q    [CORDIC_STEPS];
	logic signed [VEC_W-1:0] b_q    [CORDIC_STEPS];
	logic [PHASE_W-1:0]      p_q    [CORDIC_STEPS];
	logic                    done_q [CORDIC_STEPS];

	// fold the left half plane over and settle the axis cases up front
	always_comb begin
		na    = a_in;
		nb    = b_in;
		p0    = '0;
		done0 = 1'b0;
		if (b_in < 0) begin
			na = -a_in;
			nb = -b_in;
			p0 = PHASE_HALF;
		end
		if (b_in == '0) begin
			done0 = 1'b1;
			if (a_in == '0) begin
				p0 = '0;
			end else if (a_in > 0) begin
				p0 = PHASE_QUARTER;
			end else begin
				p0 = PHASE_3QUART;
			end
		end else if (na == '0) begin
			done0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a0_q    <= na;
			b0_q    <= nb;
			p0_q    <= p0;
			done0_q <= done0;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [VEC_W-1:0] a_i;
		logic signed [VEC_W-1:0] b_i;
		logic [PHASE_W-1:0]      p_i;
		logic                    done_i;

		if (i == 0) begin : g_first
			assign a_i    = a0_q;
			assign b_i    = b0_q;
			assign p_i    = p0_q;
			assign done_i = done0_q;
		end else begin : g_next
			assign a_i    = a_q[i-1];
			assign b_i    = b_q[i-1];
			assign p_i    = p_q[i-1];
			assign done_i = done_q[i-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (a_i > 0) begin
					b_q[i] <= b_i + (a_i >>> i);
					a_q[i] <= a_i - (b_i >>> i);
				end else begin
					b_q[i] <= b_i - (a_i >>> i);
					a_q[i] <= a_i + (b_i >>> i);
				end
				// hold a phase that was settled before the iterations
				if (done_i) begin
					p_q[i] <= p_i;
				end else if (a_i > 0) begin
					p_q[i] <= p_i + ATAN_TURNS[i];
				end else begin
					p_q[i] <= p_i - ATAN_TURNS[i];
				end
				done_q[i] <= done_i;
			end
		end
	end

	assign phase = p_q[CORDIC_STEPS-1];

endmodule

>>> rtl/core/equirect_env_map_lookup.sv
// Top level: equirectangular environment map lookup with texel store.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, action, dir_*, texel_* | request in
//  out     | out_valid, out_stall, red..blue, column, row | result out
//
// One request per cycle while in_stall is low.
// Stages in order: squares, square root (one bit per stage), CORDIC,
// scale/fold/address, texel store read.
// Writes travel the same pipeline and update the store in request order.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears the valid bits only; the store holds garbage until written.
`timescale 1ns / 1ps
`include "equirect_env_map_lookup_assert.svh"
module equirect_env_map_lookup import eqmap_pkg::*; #(
	parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
	parameter int MAP_HEIGHT = MAP_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [15:0] dir_x,
	input  logic signed [15:0] dir_y,
	input  logic signed [15:0] dir_z,
	input  logic [16:0]        texel_index,
	input  logic [7:0]         texel_red,
	input  logic [7:0]         texel_green,
	input  logic [7:0]         texel_blue,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [8:0]         column,
	output logic [7:0]         row
);

	localparam int FRONT_LAT = 1 + SQRT_STAGES + CORDIC_LAT;
	localparam int SQRT_TAP  = SQRT_STAGES;
	localparam logic [DIM_W-1:0] W_C  = DIM_W'(MAP_WIDTH);
	localparam logic [DIM_W-1:0] H2_C = DIM_W'(2 * MAP_HEIGHT);
	localparam logic [COL_W-1:0] H_C  = COL_W'(MAP_HEIGHT);

	logic en;
	logic out_valid_q;

	item_t              pipe_q [FRONT_LAT];
	logic               vld_q  [FRONT_LAT];
	logic [SUMSQ_W-1:0] sumsq_s1;
	logic signed [31:0] xx;
	logic signed [31:0] zz;

	logic [ROOT_W-1:0]       root;
	logic signed [VEC_W-1:0] a_col;
	logic signed [VEC_W-1:0] b_col;
	logic signed [VEC_W-1:0] a_row;
	logic signed [VEC_W-1:0] b_row;
	logic [PHASE_W-1:0]      pc;
	logic [PHASE_W-1:0]      pr;
	item_t                   tap;
	item_t                   last;

	logic [44:0]         pc_prod;
	logic [44:0]         pr_prod;
	logic [COL_W-1:0]    col_s61;
	logic [COL_W-1:0]    rraw_s61;
	item_t               item_s61;
	logic                vld_s61;
	logic [COL_W-1:0]    col_s62;
	logic [ROW_W-1:0]    row_s62;
	item_t               item_s62;
	logic                vld_s62;
	logic [COL_W-1:0]    col_s63;
	logic [ROW_W-1:0]    row_s63;
	logic [STORE_AW-1:0] addr_s63;
	item_t               item_s63;
	logic                vld_s63;
	logic [23:0]         addr_full;

	logic [TEXEL_W-1:0]  mem [STORE_DEPTH];
	logic [TEXEL_W-1:0]  rd_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;

	// advance everything unless a finished result is held back
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	assign xx = dir_x * dir_x;
	assign zz = dir_z * dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRONT_LAT; j++) begin
				vld_q[j] <= 1'b0;
			end
			vld_s61     <= 1'b0;
			vld_s62     <= 1'b0;
			vld_s63     <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int j = 1; j < FRONT_LAT; j++) begin
				vld_q[j] <= vld_q[j-1];
			end
			vld_s61     <= vld_q[FRONT_LAT-1];
			vld_s62     <= vld_s61;
			vld_s63     <= vld_s62;
			out_valid_q <= vld_s63 && (item_s63.action == ACT_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_q[0].action      <= action_t'(action);
			pipe_q[0].dir_x       <= dir_x;
			pipe_q[0].dir_y       <= dir_y;
			pipe_q[0].dir_z       <= dir_z;
			pipe_q[0].texel_index <= texel_index;
			pipe_q[0].texel       <= {texel_blue, texel_green, texel_red};
			sumsq_s1              <= SUMSQ_W'(xx) + SUMSQ_W'(zz);
			for (int j = 1; j < FRONT_LAT; j++) begin
				pipe_q[j] <= pipe_q[j-1];
			end
		end
	end

	eqmap_sqrt u_sqrt (
		.clk   (clk),
		.en    (en),
		.sumsq (sumsq_s1),
		.root  (root)
	);

	assign tap   = pipe_q[SQRT_TAP];
	assign a_col = VEC_W'(tap.dir_z) <<< 14;
	assign b_col = VEC_W'(tap.dir_x) <<< 14;
	assign a_row = -(VEC_W'(tap.dir_y) <<< 14);
	assign b_row = -$signed(VEC_W'(root));

	eqmap_cordic u_cordic_col (
		.clk   (clk),
		.en    (en),
		.a_in  (a_col),
		.b_in  (b_col),
		.phase (pc)
	);

	eqmap_cordic u_cordic_row (
		.clk   (clk),
		.en    (en),
		.a_in  (a_row),
		.b_in  (b_row),
		.phase (pr)
	);

	assign last    = pipe_q[FRONT_LAT-1];
	assign pc_prod = 45'(pc) * 45'(W_C);
	assign pr_prod = 45'(pr) * 45'(H2_C);
	assign addr_full = 24'(col_s62) + 24'(row_s62) * 24'(W_C);

	always_ff @(posedge clk) begin
		if (en) begin
			col_s61  <= pc_prod[PHASE_W +: COL_W];
			rraw_s61 <= pr_prod[PHASE_W +: COL_W];
			item_s61 <= last;

			col_s62  <= col_s61;
			row_s62  <= (rraw_s61 >= H_C) ? ROW_W'(rraw_s61 - H_C) : ROW_W'(rraw_s61);
			item_s62 <= item_s61;

			col_s63  <= col_s62;
			row_s63  <= row_s62;
			addr_s63 <= addr_full[STORE_AW-1:0];
			item_s63 <= item_s62;
		end
	end

	// store: write in request order, registered read
	always_ff @(posedge clk) begin
		if (en && vld_s63 && (item_s63.action == ACT_WRITE)) begin
			mem[item_s63.texel_index] <= item_s63.texel;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q  <= mem[addr_s63];
			col_q <= col_s63;
			row_q <= row_s63;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = rd_q[7:0];
	assign green     = rd_q[15:8];
	assign blue      = rd_q[23:16];
	assign column    = col_q[8:0];
	assign row       = row_q[7:0];

	`EQMAP_ASSERT_NOW(a_col_in_map, out_valid_q, (COL_W+1)'(col_q) < (COL_W+1)'(MAP_WIDTH))
	`EQMAP_ASSERT_NOW(a_row_in_map, out_valid_q, (ROW_W+1)'(row_q) < (ROW_W+1)'(MAP_HEIGHT))
	`EQMAP_ASSERT_NEXT(a_write_silent, en && vld_s63 && (item_s63.action == ACT_WRITE), !out_valid_q)
	`EQMAP_ASSERT_NEXT(a_hold_result, out_valid_q && out_stall, out_valid_q && $stable(rd_q))

endmodule

>>> dv/equirect_env_map_lookup_tb.sv
// Testbench for the environment map lookup: texel writes, direction lookups, stall pressure.
`timescale 1ns / 1ps
module equirect_env_map_lookup_tb;
	import eqmap_pkg::*;

	localparam int MAP_W = 512;
	localparam int MAP_H = 256;
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 150;
	localparam int PRESSURE_CYCLES = 400;

	typedef struct {
		action_t            action;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic signed [15:0] dz;
		logic [16:0]        index;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
	} map_request_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [8:0] col;
		logic [7:0] row;
	} texel_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic signed [15:0] dir_x = '0;
	logic signed [15:0] dir_y = '0;
	logic signed [15:0] dir_z = '0;
	logic [16:0] texel_index = '0;
	logic [7:0] texel_red = '0;
	logic [7:0] texel_green = '0;
	logic [7:0] texel_blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] red, green, blue;
	logic [8:0] column;
	logic [7:0] row;

	map_request_t pending_requests[$];
	texel_hit_t expected_hits[$];
	logic [23:0] texel_mirror[int];
	bit stored_cells[int];
	int requests_total;
	int requests_sent;
	int lookups_sent;
	int writes_sent;
	int hits_seen;
	int mismatches;
	int idle_cycles;
	bit pressure_done;

	equirect_env_map_lookup dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.texel_index(texel_index), .texel_red(texel_red),
		.texel_green(texel_green), .texel_blue(texel_blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.red(red), .green(green), .blue(blue), .column(column), .row(row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n -= r + bitv;
				r = (r >> 1) + bitv;
			end else begin
				r >>= 1;
			end
			bitv >>= 2;
		end
		return r;
	endfunction

	// Phase of atan2(a, b) in 2^-32 turns by vectoring rotation.
	function automatic logic [31:0] turn_angle(longint a, longint b);
		logic [31:0] p;
		longint da, db;
		p = '0;
		if (a == 0 && b == 0)
			return '0;
		if (b == 0)
			return (a > 0) ? PHASE_QUARTER : PHASE_3QUART;
		if (b < 0) begin
			a = -a;
			b = -b;
			p = PHASE_HALF;
		end
		if (a == 0)
			return p;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (a > 0) begin
				b += db;
				a -= da;
				p += ATAN_TURNS[i];
			end else begin
				b -= db;
				a += da;
				p -= ATAN_TURNS[i];
			end
		end
		return p;
	endfunction

	// Column and row of the map cell a direction points at.
	function automatic texel_hit_t map_cell(logic signed [15:0] dx, logic signed [15:0] dy,
			logic signed [15:0] dz);
		texel_hit_t h;
		longint x, y, z;
		longint unsigned rsq;
		logic [31:0] pc, pr;
		longint unsigned cl, rw;
		x = dx;
		y = dy;
		z = dz;
		pc = turn_angle(z * 16384, x * 16384);
		rsq = longint'(x * x + z * z) << 28;
		pr = turn_angle(-(y * 16384), -longint'(int_sqrt(rsq)));
		cl = ((longint'(pc) * MAP_W) >> 32) % MAP_W;
		rw = ((longint'(pr) * (2 * MAP_H)) >> 32) % MAP_H;
		h.col = cl[8:0];
		h.row = rw[7:0];
		h.r = '0;
		h.g = '0;
		h.b = '0;
		return h;
	endfunction

	function automatic int cell_address(texel_hit_t h);
		return (int'(h.col) + MAP_W * int'(h.row)) % STORE_DEPTH;
	endfunction

	task automatic add_write(int index, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		map_request_t q;
		q.action = ACT_WRITE;
		q.dx = 16'($urandom);
		q.dy = 16'($urandom);
		q.dz = 16'($urandom);
		q.index = index[16:0];
		q.r = r;
		q.g = g;
		q.b = b;
		stored_cells[index] = 1'b1;
		pending_requests.push_back(q);
	endtask

	// Queue a lookup, preceded by a write when its cell was never filled.
	task automatic add_lookup(int x, int y, int z);
		map_request_t q;
		int addr;
		addr = cell_address(map_cell(16'(x), 16'(y), 16'(z)));
		if (!stored_cells.exists(addr))
			add_write(addr, 8'($urandom), 8'($urandom), 8'($urandom));
		q.action = ACT_LOOKUP;
		q.dx = 16'(x);
		q.dy = 16'(y);
		q.dz = 16'(z);
		q.index = 17'($urandom);
		q.r = 8'($urandom);
		q.g = 8'($urandom);
		q.b = 8'($urandom);
		pending_requests.push_back(q);
	endtask

	function automatic int pick_component();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2: return $urandom_range(0, 8) - 4;
			3: return $urandom_range(0, 1) ? 16384 : -16384;
			default: return $urandom_range(0, 32768) - 16384;
		endcase
	endfunction

	initial begin
		add_write(0, 8'h00, 8'h00, 8'h00);
		add_write(131071, 8'hFF, 8'hFF, 8'hFF);
		add_write(65535, 8'hA5, 8'h5A, 8'hFF);
		// zero vector, each axis both ways, extreme diagonals
		add_lookup(0, 0, 0);
		add_lookup(16384, 0, 0);
		add_lookup(-16384, 0, 0);
		add_lookup(0, 0, 16384);
		add_lookup(0, 0, -16384);
		add_lookup(0, 16384, 0);
		add_lookup(0, -16384, 0);
		add_lookup(16384, 16384, 16384);
		add_lookup(-16384, -16384, -16384);
		add_lookup(-16384, 16384, 16384);
		add_lookup(16384, -16384, -16384);
		add_lookup(-1, 0, 1);
		add_lookup(1, -1, -1);
		add_lookup(-16384, 1, 0);
		add_lookup(0, -1, -16384);
		add_lookup(16383, -16383, -16383);
		while (pending_requests.size() < 550) begin
			if ($urandom_range(0, 6) == 0)
				add_write($urandom_range(0, 131071), 8'($urandom), 8'($urandom),
					8'($urandom));
			else
				add_lookup(pick_component(), pick_component(), pick_component());
		end
		requests_total = pending_requests.size();
	end

	function automatic int draw_gap(int count);
		// leave every third stretch of 100 without idling
		if ((count / 100) % 3 == 1)
			return 0;
		return $urandom_range(0, 5);
	endfunction

	int send_gap = 0;
	map_request_t active_request;

	always @(posedge clk or negedge arst_n) begin
		texel_hit_t h;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				requests_sent++;
				if (active_request.action == ACT_WRITE) begin
					writes_sent++;
					texel_mirror[int'(active_request.index)] = {active_request.b,
						active_request.g, active_request.r};
				end else begin
					lookups_sent++;
					h = map_cell(active_request.dx, active_request.dy, active_request.dz);
					{h.b, h.g, h.r} = texel_mirror[cell_address(h)];
					expected_hits.push_back(h);
				end
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_requests.size() > 0) begin
					active_request = pending_requests.pop_front();
					in_valid <= 1'b1;
					action <= active_request.action;
					dir_x <= active_request.dx;
					dir_y <= active_request.dy;
					dir_z <= active_request.dz;
					texel_index <= active_request.index;
					texel_red <= active_request.r;
					texel_green <= active_request.g;
					texel_blue <= active_request.b;
					send_gap = draw_gap(requests_sent);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	int recv_wait = 0;

	always @(posedge clk or negedge arst_n) begin
		texel_hit_t h;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				hits_seen++;
				if (expected_hits.size() == 0) begin
					$error("result with no lookup outstanding: column %0d row %0d",
						column, row);
					mismatches++;
				end else begin
					h = expected_hits.pop_front();
					if (red !== h.r) begin
						$error("red expected %0d actual %0d", h.r, red);
						mismatches++;
					end
					if (green !== h.g) begin
						$error("green expected %0d actual %0d", h.g, green);
						mismatches++;
					end
					if (blue !== h.b) begin
						$error("blue expected %0d actual %0d", h.b, blue);
						mismatches++;
					end
					if (column !== h.col) begin
						$error("column expected %0d actual %0d", h.col, column);
						mismatches++;
					end
					if (row !== h.row) begin
						$error("row expected %0d actual %0d", h.row, row);
						mismatches++;
					end
				end
				// hold off long once so the pipeline backs up into in_stall
				if (hits_seen == 60 && !pressure_done) begin
					pressure_done = 1'b1;
					recv_wait = PRESSURE_CYCLES;
				end else begin
					recv_wait = draw_gap(hits_seen);
				end
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait > 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no progress, %0d of %0d requests sent, %0d results pending",
					requests_sent, requests_total, expected_hits.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		wait (requests_total > 0 && requests_sent == requests_total);
		wait (expected_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d lookups, %0d texel writes, %0d results checked",
			requests_sent, lookups_sent, writes_sent, hits_seen);
		$display("axes, zero vector and extreme directions included; one long output hold");
		if (mismatches == 0 && expected_hits.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
